### rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed in %m");
`define ASSERT_NEVER(lbl, cond, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition in %m");
`else
`define ASSERT_PROP(lbl, prop, clk, rst_n)
`define ASSERT_NEVER(lbl, cond, clk, rst_n)
`endif
`endif

### rtl/nnra_pkg.sv
// types, constants and helpers of the resize address generator
package nnra_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned Q_W     = $clog2(MAX_DIM);
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned ADDR_W  = 28;
  localparam int unsigned COFF_W  = Q_W + BPP_W;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [Q_W-1:0]     idx_t;
  typedef logic [Q_W:0]       trial_t;
  typedef logic [2*Q_W-1:0]   prod_t;
  typedef logic [2*Q_W:0]     num_t;
  typedef logic [PITCH_W-1:0] pitch_t;
  typedef logic [BPP_W-1:0]   bpp_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COFF_W-1:0]  coff_t;

  typedef enum logic [2:0] {
    REG_SRC_W     = 3'd0,
    REG_SRC_H     = 3'd1,
    REG_TGT_W     = 3'd2,
    REG_TGT_H     = 3'd3,
    REG_SRC_PITCH = 3'd4,
    REG_TGT_PITCH = 3'd5,
    REG_PIX_BYTES = 3'd6
  } reg_idx_e;

  localparam bpp_t BPP_MIN = 3'd2;
  localparam bpp_t BPP_MAX = 3'd4;

  typedef struct packed {
    logic [11:0] dest_col;
    logic [11:0] dest_row;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] src_col;
    logic [11:0] src_row;
    logic [27:0] src_byte_addr;
    logic [27:0] dst_byte_addr;
    logic        out_of_range;
  } out_beat_t;

  typedef struct packed {
    dim_t   src_w;
    dim_t   src_h;
    dim_t   tgt_w;
    dim_t   tgt_h;
    pitch_t src_pitch;
    pitch_t tgt_pitch;
    bpp_t   bpp;
  } cfg_t;

  // clamped view of the registers plus the derived divisors
  typedef struct packed {
    dim_t   src_w;
    dim_t   src_h;
    dim_t   tgt_w;
    dim_t   tgt_h;
    idx_t   src_w_m1;
    idx_t   src_h_m1;
    idx_t   tgt_w_m1;
    idx_t   tgt_h_m1;
    pitch_t src_pitch;
    pitch_t tgt_pitch;
    bpp_t   bpp;
  } eff_t;

  typedef struct packed {
    idx_t dest_col;
    idx_t dest_row;
    logic oor;
  } side_t;

  // rem: partial remainder, bits: dividend bits still to come, quotient bits shifted in
  typedef struct packed {
    idx_t rem;
    idx_t bits;
  } div_lane_t;

  typedef struct packed {
    div_lane_t col;
    div_lane_t row;
    side_t     side;
  } div_item_t;

  function automatic dim_t clamp_dim(dim_t v);
    dim_t r;
    r = v;
    if (v == dim_t'(0)) begin
      r = dim_t'(1);
    end else if (v > dim_t'(MAX_DIM)) begin
      r = dim_t'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic bpp_t clamp_bpp(bpp_t v);
    bpp_t r;
    r = v;
    if (v < BPP_MIN) begin
      r = BPP_MIN;
    end else if (v > BPP_MAX) begin
      r = BPP_MAX;
    end
    return r;
  endfunction

endpackage

### rtl/nnra_prep.sv
// front stages: range check, scale products and rounded dividends
module nnra_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nnra_pkg::eff_t       eff_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nnra_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output nnra_pkg::div_item_t  out_item_o
);

  typedef struct packed {
    nnra_pkg::prod_t prod_col;
    nnra_pkg::prod_t prod_row;
    nnra_pkg::side_t side;
  } prod_stage_t;

  logic                v1_q, v2_q;
  logic                rdy1, rdy2;
  prod_stage_t         p1_d, p1_q;
  nnra_pkg::div_item_t item_d, item_q;
  nnra_pkg::num_t      num_col, num_row;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    p1_d.side.dest_col = in_beat_i.dest_col;
    p1_d.side.dest_row = in_beat_i.dest_row;
    p1_d.side.oor      = ({1'b0, in_beat_i.dest_col} >= eff_i.tgt_w) ||
                         ({1'b0, in_beat_i.dest_row} >= eff_i.tgt_h);
    p1_d.prod_col      = nnra_pkg::prod_t'(in_beat_i.dest_col) *
                         nnra_pkg::prod_t'(eff_i.src_w_m1);
    p1_d.prod_row      = nnra_pkg::prod_t'(in_beat_i.dest_row) *
                         nnra_pkg::prod_t'(eff_i.src_h_m1);
  end

  // ceil division: add divisor minus one before dividing
  always_comb begin
    num_col = '0;
    num_row = '0;
    if (eff_i.tgt_w_m1 != '0) begin
      num_col = nnra_pkg::num_t'(p1_q.prod_col) + nnra_pkg::num_t'(eff_i.tgt_w_m1) -
                nnra_pkg::num_t'(1);
    end
    if (eff_i.tgt_h_m1 != '0) begin
      num_row = nnra_pkg::num_t'(p1_q.prod_row) + nnra_pkg::num_t'(eff_i.tgt_h_m1) -
                nnra_pkg::num_t'(1);
    end
    item_d.col.rem  = num_col[2*nnra_pkg::Q_W-1:nnra_pkg::Q_W];
    item_d.col.bits = num_col[nnra_pkg::Q_W-1:0];
    item_d.row.rem  = num_row[2*nnra_pkg::Q_W-1:nnra_pkg::Q_W];
    item_d.row.bits = num_row[nnra_pkg::Q_W-1:0];
    item_d.side     = p1_q.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p1_q <= p1_d;
    end
    if (rdy2 && v1_q) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item_q;

endmodule

### rtl/nnra_div_cell.sv
// one restoring division step for both axes, one quotient bit per cell
module nnra_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nnra_pkg::eff_t       eff_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nnra_pkg::div_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output nnra_pkg::div_item_t  out_item_o
);

  logic                valid_q;
  nnra_pkg::div_item_t item_d, item_q;

  function automatic nnra_pkg::div_lane_t div_step(nnra_pkg::div_lane_t l,
                                                   nnra_pkg::idx_t den);
    nnra_pkg::trial_t    trial;
    logic                ge;
    nnra_pkg::div_lane_t r;
    trial  = {l.rem, l.bits[nnra_pkg::Q_W-1]};
    ge     = trial >= {1'b0, den};
    r.rem  = ge ? nnra_pkg::idx_t'(trial - {1'b0, den}) : nnra_pkg::idx_t'(trial);
    r.bits = {l.bits[nnra_pkg::Q_W-2:0], ge};
    return r;
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    item_d.col  = div_step(in_item_i.col, eff_i.tgt_w_m1);
    item_d.row  = div_step(in_item_i.row, eff_i.tgt_h_m1);
    item_d.side = in_item_i.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

### rtl/nnra_addr.sv
// back stages: index clamp, address products and the output register
module nnra_addr (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nnra_pkg::eff_t       eff_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nnra_pkg::div_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output nnra_pkg::out_beat_t  out_beat_o
);

  typedef struct packed {
    nnra_pkg::idx_t  src_col;
    nnra_pkg::idx_t  src_row;
    nnra_pkg::addr_t src_row_off;
    nnra_pkg::coff_t src_col_off;
    nnra_pkg::addr_t dst_row_off;
    nnra_pkg::coff_t dst_col_off;
    logic            oor;
  } addr_stage_t;

  logic                v1_q, v2_q;
  logic                rdy1, rdy2;
  addr_stage_t         a1_d, a1_q;
  nnra_pkg::out_beat_t beat_d, beat_q;
  nnra_pkg::idx_t      q_col, q_row, sc, sr;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign q_col = in_item_i.col.bits;
  assign q_row = in_item_i.row.bits;

  always_comb begin
    sc = q_col;
    if (eff_i.tgt_w_m1 == '0) begin
      sc = '0;
    end else if ({1'b0, q_col} >= eff_i.src_w) begin
      sc = eff_i.src_w_m1;
    end
    sr = q_row;
    if (eff_i.tgt_h_m1 == '0) begin
      sr = '0;
    end else if ({1'b0, q_row} >= eff_i.src_h) begin
      sr = eff_i.src_h_m1;
    end
    a1_d.src_col     = sc;
    a1_d.src_row     = sr;
    a1_d.src_row_off = nnra_pkg::addr_t'(sr) * nnra_pkg::addr_t'(eff_i.src_pitch);
    a1_d.src_col_off = nnra_pkg::coff_t'(sc) * nnra_pkg::coff_t'(eff_i.bpp);
    a1_d.dst_row_off = nnra_pkg::addr_t'(in_item_i.side.dest_row) *
                       nnra_pkg::addr_t'(eff_i.tgt_pitch);
    a1_d.dst_col_off = nnra_pkg::coff_t'(in_item_i.side.dest_col) *
                       nnra_pkg::coff_t'(eff_i.bpp);
    a1_d.oor         = in_item_i.side.oor;
  end

  always_comb begin
    beat_d = '0;
    beat_d.out_of_range = a1_q.oor;
    if (!a1_q.oor) begin
      beat_d.src_col       = a1_q.src_col;
      beat_d.src_row       = a1_q.src_row;
      beat_d.src_byte_addr = a1_q.src_row_off + nnra_pkg::addr_t'(a1_q.src_col_off);
      beat_d.dst_byte_addr = a1_q.dst_row_off + nnra_pkg::addr_t'(a1_q.dst_col_off);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      a1_q <= a1_d;
    end
    if (rdy2 && v1_q) begin
      beat_q <= beat_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_beat_o  = beat_q;

endmodule

### rtl/nearest_neighbor_resize_address.sv
// top level of the nearest neighbor resize address generator
//
//   port group   direction  kind           payload
//   in_*         in         valid/ready    in_beat_i: dest_col, dest_row
//   out_*        out        valid/ready    out_beat_o: src/dst indices and addresses
//   apb          in/out     apb, 5b addr   seven config registers at 4*i
//
// one beat per cycle sustained while out_ready_i does not stall the output
// pipeline of 2 front stages, 12 divider cells (one quotient bit each) and 2 address stages
// every stage holds its beat when the next one is full, bubbles close up
// reset empties the pipeline and loads the register defaults
module nearest_neighbor_resize_address (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nnra_pkg::APB_AW-1:0]   paddr,
  input  logic [nnra_pkg::APB_DW-1:0]   pwdata,
  output logic [nnra_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  nnra_pkg::in_beat_t            in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output nnra_pkg::out_beat_t           out_beat_o
);

  `include "assert_macros.svh"

  localparam int unsigned NCELL = nnra_pkg::Q_W;

  nnra_pkg::cfg_t      cfg_q;
  nnra_pkg::eff_t      eff;
  nnra_pkg::reg_idx_e  reg_idx;
  logic                wr_en;

  logic                chain_valid [NCELL+1];
  logic                chain_ready [NCELL+1];
  nnra_pkg::div_item_t chain_item  [NCELL+1];

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = nnra_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w     <= nnra_pkg::dim_t'(1);
      cfg_q.src_h     <= nnra_pkg::dim_t'(1);
      cfg_q.tgt_w     <= nnra_pkg::dim_t'(1);
      cfg_q.tgt_h     <= nnra_pkg::dim_t'(1);
      cfg_q.src_pitch <= nnra_pkg::pitch_t'(1);
      cfg_q.tgt_pitch <= nnra_pkg::pitch_t'(1);
      cfg_q.bpp       <= nnra_pkg::BPP_MAX;
    end else if (wr_en) begin
      unique case (reg_idx)
        nnra_pkg::REG_SRC_W:     cfg_q.src_w     <= pwdata[nnra_pkg::DIM_W-1:0];
        nnra_pkg::REG_SRC_H:     cfg_q.src_h     <= pwdata[nnra_pkg::DIM_W-1:0];
        nnra_pkg::REG_TGT_W:     cfg_q.tgt_w     <= pwdata[nnra_pkg::DIM_W-1:0];
        nnra_pkg::REG_TGT_H:     cfg_q.tgt_h     <= pwdata[nnra_pkg::DIM_W-1:0];
        nnra_pkg::REG_SRC_PITCH: cfg_q.src_pitch <= pwdata[nnra_pkg::PITCH_W-1:0];
        nnra_pkg::REG_TGT_PITCH: cfg_q.tgt_pitch <= pwdata[nnra_pkg::PITCH_W-1:0];
        nnra_pkg::REG_PIX_BYTES: cfg_q.bpp       <= pwdata[nnra_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      nnra_pkg::REG_SRC_W:     prdata = nnra_pkg::APB_DW'(cfg_q.src_w);
      nnra_pkg::REG_SRC_H:     prdata = nnra_pkg::APB_DW'(cfg_q.src_h);
      nnra_pkg::REG_TGT_W:     prdata = nnra_pkg::APB_DW'(cfg_q.tgt_w);
      nnra_pkg::REG_TGT_H:     prdata = nnra_pkg::APB_DW'(cfg_q.tgt_h);
      nnra_pkg::REG_SRC_PITCH: prdata = nnra_pkg::APB_DW'(cfg_q.src_pitch);
      nnra_pkg::REG_TGT_PITCH: prdata = nnra_pkg::APB_DW'(cfg_q.tgt_pitch);
      nnra_pkg::REG_PIX_BYTES: prdata = nnra_pkg::APB_DW'(cfg_q.bpp);
      default:                 prdata = '0;
    endcase
  end

  // clamped dims, divisors; user keeps them stable while beats are in flight, not enforced
  always_comb begin
    eff.src_w     = nnra_pkg::clamp_dim(cfg_q.src_w);
    eff.src_h     = nnra_pkg::clamp_dim(cfg_q.src_h);
    eff.tgt_w     = nnra_pkg::clamp_dim(cfg_q.tgt_w);
    eff.tgt_h     = nnra_pkg::clamp_dim(cfg_q.tgt_h);
    eff.src_w_m1  = nnra_pkg::idx_t'(eff.src_w - nnra_pkg::dim_t'(1));
    eff.src_h_m1  = nnra_pkg::idx_t'(eff.src_h - nnra_pkg::dim_t'(1));
    eff.tgt_w_m1  = nnra_pkg::idx_t'(eff.tgt_w - nnra_pkg::dim_t'(1));
    eff.tgt_h_m1  = nnra_pkg::idx_t'(eff.tgt_h - nnra_pkg::dim_t'(1));
    eff.src_pitch = cfg_q.src_pitch;
    eff.tgt_pitch = cfg_q.tgt_pitch;
    eff.bpp       = nnra_pkg::clamp_bpp(cfg_q.bpp);
  end

  nnra_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_i       (eff),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_item_o  (chain_item[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    nnra_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .eff_i       (eff),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_item_i   (chain_item[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_item_o  (chain_item[g+1])
    );
  end

  nnra_addr u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_i       (eff),
    .in_valid_i  (chain_valid[NCELL]),
    .in_ready_o  (chain_ready[NCELL]),
    .in_item_i   (chain_item[NCELL]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  `ASSERT_PROP(a_oor_zero, (out_valid_o && out_beat_o.out_of_range) |-> (out_beat_o.src_col == '0 && out_beat_o.src_row == '0 && out_beat_o.src_byte_addr == '0 && out_beat_o.dst_byte_addr == '0), clk_i, rst_ni)
  `ASSERT_PROP(a_src_in_bounds, (out_valid_o && !out_beat_o.out_of_range) |-> (out_beat_o.src_col <= eff.src_w_m1 && out_beat_o.src_row <= eff.src_h_m1), clk_i, rst_ni)
  `ASSERT_NEVER(a_no_idle_stall, !in_ready_o && !(out_valid_o && !out_ready_i), clk_i, rst_ni)

endmodule
